// ===== design/segment_triangle_hit_test_core_assert.svh =====
// Assertion macros shared by the checker of the hit test core.
// Used by design/sth_checker.sv; needs nothing else.
`ifndef SEGMENT_TRIANGLE_HIT_TEST_CORE_ASSERT_SVH
`define SEGMENT_TRIANGLE_HIT_TEST_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STH_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STH_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sth_pkg.sv =====
// Package of the segment/triangle hit test: widths, register codes and
// payload structs. Depends on nothing.
`timescale 1ns / 1ps

package sth_pkg;

  // Field widths of the channels and registers.
  localparam int COORD_W = 21;
  localparam int DIR_W   = 20;
  localparam int DIST_W  = 20;
  localparam int VERT_W  = 63;

  // Internal widths, sized to the value ranges of each quantity.
  localparam int EDGE_W = 22;
  localparam int PM_W   = 41;
  localparam int QP_W   = 25;
  localparam int NP_W   = 44;
  localparam int N_W    = 37;
  localparam int NL_W   = 18;
  localparam int EP_W   = 47;
  localparam int E_W    = 40;
  localparam int EL_W   = 20;
  localparam int DOT_W  = 64;
  localparam int D_W    = 60;
  localparam int SQ_W   = 48;
  localparam int LEN_W  = 24;
  localparam int UD_W   = 37;
  localparam int UTL_W  = 19;
  localparam int NUM_W  = 62;
  localparam int Q_W    = 24;

  localparam int SQ_STEPS   = 24;
  localparam int NORM_STEPS = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_A = 2'd0,
    CFG_VERTEX_B = 2'd1,
    CFG_VERTEX_C = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   direction_x;
    logic signed [DIR_W-1:0]   direction_y;
    logic signed [DIR_W-1:0]   direction_z;
    logic [DIST_W-1:0]         max_distance;
  } ray_t;

  // Geometry results handed to the distance pipeline.
  typedef struct packed {
    logic            hit;
    logic [D_W-1:0]  ud;
    logic [D_W-1:0]  ut;
    logic [SQ_W-1:0] qq;
  } front_res_t;

endpackage

// ===== design/sth_if.sv =====
// Channel interfaces of the hit test core: ray beats in, result beats out.
// Depends on sth_pkg for the field widths.
`timescale 1ns / 1ps

interface sth_ray_if import sth_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [DIR_W-1:0]   direction_x;
  logic signed [DIR_W-1:0]   direction_y;
  logic signed [DIR_W-1:0]   direction_z;
  logic [DIST_W-1:0]         max_distance;

  modport source (output valid, origin_x, origin_y, origin_z, direction_x,
                  direction_y, direction_z, max_distance, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, direction_x,
                direction_y, direction_z, max_distance, output ready);
endinterface

interface sth_hit_if import sth_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

// ===== design/segment_triangle_hit_test_core.sv =====
// Top level of the segment/triangle hit test: vertex registers, geometry
// and distance pipelines, output skid stage. Depends on sth_pkg, sth_if,
// sth_front and sth_dist.
//
// Use: write the three vertices through cfg_we/cfg_index/cfg_data while no
// ray is in flight. Each ray beat on the ray channel (origin, direction,
// length) yields exactly one result beat on the result channel, in order:
// hit, and the distance to the crossing in Q12.8, saturated, zero on a miss.
// There are 58 register stages: seven geometry stages, 24 square root steps,
// two multiply stages, 24 division steps and one saturation stage.
// Throughput is one ray per cycle while the skid register is empty; every
// stage then takes a new ray each cycle.
// When the receiver stalls, the last result moves into a skid register and
// ray ready drops in the next cycle; the pipe holds until the skid drains,
// so nothing is lost or repeated.
// Reset clears the vertex registers to zero and all valid bits, leaving the
// pipe empty with ray ready high.
`timescale 1ns / 1ps

module segment_triangle_hit_test_core import sth_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VERT_W-1:0]    cfg_data,
  sth_ray_if.sink              ray,
  sth_hit_if.source            result
);

  logic [VERT_W-1:0] vertex_a;
  logic [VERT_W-1:0] vertex_b;
  logic [VERT_W-1:0] vertex_c;

  // Vertex registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_A: vertex_a <= cfg_data;
        CFG_VERTEX_B: vertex_b <= cfg_data;
        CFG_VERTEX_C: vertex_c <= cfg_data;
        default: ;
      endcase
    end
  end

  logic              en;
  logic              skid_valid;
  logic              skid_hit;
  logic [DIST_W-1:0] skid_dist;
  ray_t              ray_d;
  logic              f_valid;
  front_res_t        f_res;
  logic              p_valid;
  logic              p_hit;
  logic [DIST_W-1:0] p_dist;

  // The whole pipe advances unless the skid register holds a beat.
  assign en        = !skid_valid;
  assign ray.ready = en;

  assign ray_d = '{origin_x:     ray.origin_x,
                   origin_y:     ray.origin_y,
                   origin_z:     ray.origin_z,
                   direction_x:  ray.direction_x,
                   direction_y:  ray.direction_y,
                   direction_z:  ray.direction_z,
                   max_distance: ray.max_distance};

  sth_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ray.valid),
    .ray      (ray_d),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .out_valid(f_valid),
    .res      (f_res)
  );

  sth_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (f_valid),
    .res         (f_res),
    .out_valid   (p_valid),
    .hit         (p_hit),
    .hit_distance(p_dist)
  );

  // Skid register catches the pipe's last beat when the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      skid_valid <= p_valid && !result.ready;
    end else if (result.ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_hit  <= p_hit;
      skid_dist <= p_dist;
    end
  end

  assign result.valid        = skid_valid || p_valid;
  assign result.hit          = skid_valid ? skid_hit : p_hit;
  assign result.hit_distance = skid_valid ? skid_dist : p_dist;

endmodule

// ===== design/sth_front.sv =====
// Geometry pipeline: edges, normal, cross product and the dot product tests.
// Seven register stages. Depends on sth_pkg.
`timescale 1ns / 1ps

module sth_front import sth_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ray_t              ray,
  input  logic [VERT_W-1:0] vertex_a,
  input  logic [VERT_W-1:0] vertex_b,
  input  logic [VERT_W-1:0] vertex_c,
  output logic              out_valid,
  output front_res_t        res
);

  logic signed [COORD_W-1:0] va [3];
  logic signed [COORD_W-1:0] vb [3];
  logic signed [COORD_W-1:0] vc [3];
  logic signed [COORD_W-1:0] org [3];
  logic signed [DIR_W-1:0]   dir [3];

  // Unpack the vertices and the ray.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = $signed(vertex_a[COORD_W*i +: COORD_W]);
      vb[i] = $signed(vertex_b[COORD_W*i +: COORD_W]);
      vc[i] = $signed(vertex_c[COORD_W*i +: COORD_W]);
    end
    org[0] = ray.origin_x;
    org[1] = ray.origin_y;
    org[2] = ray.origin_z;
    dir[0] = ray.direction_x;
    dir[1] = ray.direction_y;
    dir[2] = ray.direction_z;
  end

  logic [6:0] valid;

  // Valid bits travel with the data and move only when the pipe is enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[5:0], in_valid};
    end
  end

  // Stage 1: edge and origin differences, length times direction.
  logic signed [EDGE_W-1:0] s1_ab [3];
  logic signed [EDGE_W-1:0] s1_ac [3];
  logic signed [EDGE_W-1:0] s1_ap [3];
  logic signed [PM_W-1:0]   s1_pm [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ab[i] <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
        s1_ac[i] <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
        s1_ap[i] <= EDGE_W'(org[i]) - EDGE_W'(va[i]);
        s1_pm[i] <= $signed({1'b0, ray.max_distance}) * dir[i];
      end
    end
  end

  // Stage 2: round qp to Q.8, products of the normal's cross terms.
  logic signed [QP_W-1:0]   s2_qp [3];
  logic signed [EDGE_W-1:0] s2_ab [3];
  logic signed [EDGE_W-1:0] s2_ac [3];
  logic signed [EDGE_W-1:0] s2_ap [3];
  logic signed [NP_W-1:0]   s2_na [3];
  logic signed [NP_W-1:0]   s2_nb [3];
  logic signed [PM_W+1:0]   nq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = -(PM_W+2)'(s1_pm[i]) + (PM_W+2)'(32768);
    end
  end

  always_ff @(posedge clk) begin
    int j;
    int k;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        k = (i == 0) ? 2 : i - 1;
        s2_qp[i] <= QP_W'(nq[i] >>> 16);
        s2_ab[i] <= s1_ab[i];
        s2_ac[i] <= s1_ac[i];
        s2_ap[i] <= s1_ap[i];
        s2_na[i] <= s1_ab[j] * s1_ac[k];
        s2_nb[i] <= s1_ab[k] * s1_ac[j];
      end
    end
  end

  // Stage 3: normal rounded to Q.8, products of the qp x ap cross terms.
  logic signed [N_W-1:0]    s3_n  [3];
  logic signed [QP_W-1:0]   s3_qp [3];
  logic signed [EDGE_W-1:0] s3_ab [3];
  logic signed [EDGE_W-1:0] s3_ac [3];
  logic signed [EDGE_W-1:0] s3_ap [3];
  logic signed [EP_W-1:0]   s3_ea [3];
  logic signed [EP_W-1:0]   s3_eb [3];
  logic signed [NP_W+1:0]   nd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd[i] = (NP_W+2)'(s2_na[i]) - (NP_W+2)'(s2_nb[i]) + (NP_W+2)'(128);
    end
  end

  always_ff @(posedge clk) begin
    int j;
    int k;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        k = (i == 0) ? 2 : i - 1;
        s3_n[i]  <= N_W'(nd[i] >>> 8);
        s3_qp[i] <= s2_qp[i];
        s3_ab[i] <= s2_ab[i];
        s3_ac[i] <= s2_ac[i];
        s3_ap[i] <= s2_ap[i];
        s3_ea[i] <= s2_qp[j] * s2_ap[k];
        s3_eb[i] <= s2_qp[k] * s2_ap[j];
      end
    end
  end

  // Stage 4: e rounded to Q.8; split partial products of d, t and qp.qp.
  logic signed [E_W-1:0]         s4_e  [3];
  logic signed [EDGE_W-1:0]      s4_ab [3];
  logic signed [EDGE_W-1:0]      s4_ac [3];
  logic signed [QP_W+N_W-NL_W:0] s4_dh [3];
  logic signed [QP_W+NL_W:0]     s4_dl [3];
  logic signed [EDGE_W+N_W-NL_W-1:0] s4_th [3];
  logic signed [EDGE_W+NL_W:0]   s4_tl [3];
  logic signed [2*QP_W-1:0]      s4_qq [3];
  logic signed [EP_W+1:0]        ed [3];
  logic signed [N_W-NL_W-1:0]    nh [3];
  logic signed [NL_W:0]          nl [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ed[i] = (EP_W+2)'(s3_ea[i]) - (EP_W+2)'(s3_eb[i]) + (EP_W+2)'(128);
      nh[i] = $signed(s3_n[i][N_W-1:NL_W]);
      nl[i] = $signed({1'b0, s3_n[i][NL_W-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_e[i]  <= E_W'(ed[i] >>> 8);
        s4_ab[i] <= s3_ab[i];
        s4_ac[i] <= s3_ac[i];
        s4_dh[i] <= s3_qp[i] * nh[i];
        s4_dl[i] <= s3_qp[i] * nl[i];
        s4_th[i] <= s3_ap[i] * nh[i];
        s4_tl[i] <= s3_ap[i] * nl[i];
        s4_qq[i] <= s3_qp[i] * s3_qp[i];
      end
    end
  end

  // Stage 5: sum d, t and qp.qp; split partial products of v and w.
  logic signed [DOT_W-1:0]           s5_d;
  logic signed [DOT_W-1:0]           s5_t;
  logic [SQ_W-1:0]                   s5_qq;
  logic signed [EDGE_W+E_W-EL_W-1:0] s5_vh [3];
  logic signed [EDGE_W+EL_W:0]       s5_vl [3];
  logic signed [EDGE_W+E_W-EL_W-1:0] s5_wh [3];
  logic signed [EDGE_W+EL_W:0]       s5_wl [3];
  logic signed [DOT_W-1:0]           d_sum;
  logic signed [DOT_W-1:0]           t_sum;
  logic signed [DOT_W-1:0]           q_sum;
  logic signed [E_W-EL_W-1:0]        eh [3];
  logic signed [EL_W:0]              el [3];

  always_comb begin
    d_sum = '0;
    t_sum = '0;
    q_sum = '0;
    for (int i = 0; i < 3; i++) begin
      d_sum = d_sum + (DOT_W'(s4_dh[i]) <<< NL_W) + DOT_W'(s4_dl[i]);
      t_sum = t_sum + (DOT_W'(s4_th[i]) <<< NL_W) + DOT_W'(s4_tl[i]);
      q_sum = q_sum + DOT_W'(s4_qq[i]);
      eh[i] = $signed(s4_e[i][E_W-1:EL_W]);
      el[i] = $signed({1'b0, s4_e[i][EL_W-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_d  <= d_sum;
      s5_t  <= t_sum;
      s5_qq <= q_sum[SQ_W-1:0];
      for (int i = 0; i < 3; i++) begin
        s5_vh[i] <= s4_ac[i] * eh[i];
        s5_vl[i] <= s4_ac[i] * el[i];
        s5_wh[i] <= s4_ab[i] * eh[i];
        s5_wl[i] <= s4_ab[i] * el[i];
      end
    end
  end

  // Stage 6: sum v and the negated w; test d and t.
  logic signed [DOT_W-1:0] s6_d;
  logic signed [DOT_W-1:0] s6_t;
  logic signed [DOT_W-1:0] s6_v;
  logic signed [DOT_W-1:0] s6_wn;
  logic [SQ_W-1:0]         s6_qq;
  logic                    s6_dt_ok;
  logic signed [DOT_W-1:0] v_sum;
  logic signed [DOT_W-1:0] w_sum;

  always_comb begin
    v_sum = '0;
    w_sum = '0;
    for (int i = 0; i < 3; i++) begin
      v_sum = v_sum + (DOT_W'(s5_vh[i]) <<< EL_W) + DOT_W'(s5_vl[i]);
      w_sum = w_sum + (DOT_W'(s5_wh[i]) <<< EL_W) + DOT_W'(s5_wl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d     <= s5_d;
      s6_t     <= s5_t;
      s6_v     <= v_sum;
      s6_wn    <= w_sum;
      s6_qq    <= s5_qq;
      s6_dt_ok <= (s5_d > 0) && (s5_t >= 0) && (s5_t <= s5_d);
    end
  end

  // Stage 7: barycentric tests on v and w.
  logic signed [DOT_W-1:0] w_val;

  assign w_val = -s6_wn;

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit <= s6_dt_ok && (s6_v >= 0) && (s6_v <= s6_d) && (w_val >= 0)
                 && ((s6_v + w_val) <= s6_d);
      res.ud  <= s6_d[D_W-1:0];
      res.ut  <= s6_t[D_W-1:0];
      res.qq  <= s6_qq;
    end
  end

  assign out_valid = valid[6];

endmodule

// ===== design/sth_dist.sv =====
// Distance pipeline: square root of qp.qp, normalization of t and d,
// multiply and long division, one step per stage. Depends on sth_pkg.
`timescale 1ns / 1ps

module sth_dist import sth_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  front_res_t        res,
  output logic              out_valid,
  output logic              hit,
  output logic [DIST_W-1:0] hit_distance
);

  // Square root stages; the first few also normalize t and d.
  logic [SQ_STEPS:0] sv;
  logic              sh [SQ_STEPS+1];
  logic [SQ_W-1:0]   sx [SQ_STEPS+1];
  logic [SQ_W-1:0]   sr [SQ_STEPS+1];
  logic [D_W-1:0]    sud [SQ_STEPS+1];
  logic [D_W-1:0]    sut [SQ_STEPS+1];

  assign sv[0]  = in_valid;
  assign sh[0]  = res.hit;
  assign sx[0]  = res.qq;
  assign sr[0]  = '0;
  assign sud[0] = res.ud;
  assign sut[0] = res.ut;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - g));
    logic [SQ_W:0]  trial;
    logic [D_W-1:0] ud_n;
    logic [D_W-1:0] ut_n;

    assign trial = {1'b0, sr[g]} + {1'b0, BIT};

    if (g < NORM_STEPS) begin : g_norm
      localparam int K = 16 >> g;
      localparam logic [D_W-1:0] TH = D_W'(1) << (UD_W - 1 + K);
      always_comb begin
        if (sud[g] >= TH) begin
          ud_n = sud[g] >> K;
          ut_n = sut[g] >> K;
        end else begin
          ud_n = sud[g];
          ut_n = sut[g];
        end
      end
    end else begin : g_pass
      assign ud_n = sud[g];
      assign ut_n = sut[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g+1] <= 1'b0;
      end else if (en) begin
        sv[g+1] <= sv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh[g+1]  <= sh[g];
        sud[g+1] <= ud_n;
        sut[g+1] <= ut_n;
        if ({1'b0, sx[g]} >= trial) begin
          sx[g+1] <= sx[g] - trial[SQ_W-1:0];
          sr[g+1] <= (sr[g] >> 1) + BIT;
        end else begin
          sx[g+1] <= sx[g];
          sr[g+1] <= sr[g] >> 1;
        end
      end
    end
  end

  // Multiply len by t in two halves, then add half of d for rounding.
  logic [LEN_W-1:0]         len;
  logic [UD_W-1:0]          ut_n;
  logic [1:0]               mv;
  logic                     mh [2];
  logic [UD_W-1:0]          mud;
  logic [LEN_W+UD_W-UTL_W-1:0] mph;
  logic [LEN_W+UTL_W-1:0]   mpl;
  logic [NUM_W-1:0]         num;

  assign len  = sr[SQ_STEPS][LEN_W-1:0];
  assign ut_n = sut[SQ_STEPS][UD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[0], sv[SQ_STEPS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mh[0] <= sh[SQ_STEPS];
      mud   <= sud[SQ_STEPS][UD_W-1:0];
      mph   <= len * ut_n[UD_W-1:UTL_W];
      mpl   <= len * ut_n[UTL_W-1:0];
      mh[1] <= mh[0];
      num   <= (NUM_W'(mph) << UTL_W) + NUM_W'(mpl) + NUM_W'(mud >> 1);
    end
  end

  // Stage after num uses the divisor, held in one more register to line up with num.
  logic [UD_W-1:0] mud_d;

  always_ff @(posedge clk) begin
    if (en) begin
      mud_d <= mud;
    end
  end

  // Restoring division, one quotient bit per stage, high bit first.
  logic [Q_W:0]     dv;
  logic             dh [Q_W+1];
  logic [NUM_W-1:0] drem [Q_W+1];
  logic [Q_W-1:0]   dq [Q_W+1];
  logic [UD_W-1:0]  dud [Q_W+1];

  assign dv[0]   = mv[1];
  assign dh[0]   = mh[1];
  assign drem[0] = num;
  assign dq[0]   = '0;
  assign dud[0]  = mud_d;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    localparam int SH = Q_W - 1 - g;
    logic [NUM_W-1:0] dsh;

    assign dsh = NUM_W'(dud[g]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else if (en) begin
        dv[g+1] <= dv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dh[g+1]  <= dh[g];
        dud[g+1] <= dud[g];
        if (drem[g] >= dsh) begin
          drem[g+1]  <= drem[g] - dsh;
          dq[g+1]    <= dq[g] | (Q_W'(1) << SH);
        end else begin
          drem[g+1]  <= drem[g];
          dq[g+1]    <= dq[g];
        end
      end
    end
  end

  // Saturate the distance and clear it on a miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= dh[Q_W];
      if (!dh[Q_W]) begin
        hit_distance <= '0;
      end else if (dq[Q_W] > Q_W'(DIST_MAX)) begin
        hit_distance <= DIST_MAX;
      end else begin
        hit_distance <= dq[Q_W][DIST_W-1:0];
      end
    end
  end

endmodule

// ===== design/sth_checker.sv =====
// Port checker of the hit test core and its bind to the top level.
// Depends on sth_pkg and segment_triangle_hit_test_core_assert.svh.
`timescale 1ns / 1ps
`include "segment_triangle_hit_test_core_assert.svh"

module sth_checker import sth_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              ray_valid,
  input logic              ray_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_hit,
  input logic [DIST_W-1:0] res_dist
);

  // A miss always reports zero distance.
  `STH_ASSERT_NOW(a_miss_zero, clk, rst, res_valid && !res_hit, res_dist == '0, "miss with nonzero distance")

  // A stalled result beat holds its payload.
  `STH_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_hit) && $stable(res_dist), "stalled result changed")

  // Ray ready only drops after a stalled result in the cycle before.
  `STH_ASSERT_NOW(a_ready_drop, clk, rst, !ray_ready, $past(res_valid && !res_ready), "ray ready dropped without a stall")

  // With the skid register full, the result beat stays offered.
  `STH_ASSERT_NOW(a_skid_offer, clk, rst, !ray_ready, res_valid, "skid full but no result offered")

endmodule

bind segment_triangle_hit_test_core sth_checker u_sth_checker (
  .clk      (clk),
  .rst      (rst),
  .ray_valid(ray.valid),
  .ray_ready(ray.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_hit  (result.hit),
  .res_dist (result.hit_distance)
);
